// ===== rtl/bgcm_pkg.sv =====
package bgcm_pkg;

    localparam int MV_W       = 15;
    localparam int PCT_W      = 7;
    localparam int RISE_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int K_W        = 4;
    localparam int DEN_W      = 11;
    localparam int Q_W        = 4;
    localparam int STEP_W     = 2;
    localparam int NUM_W      = 14;
    localparam int DIV_W      = NUM_W + Q_W;

    localparam int CURVE_LEN   = 12;
    localparam int BREAKPOINTS = 12;
    localparam int CURVE_PTS   = (BREAKPOINTS > CURVE_LEN) ? CURVE_LEN :
                                 ((BREAKPOINTS < 2) ? 2 : BREAKPOINTS);
    localparam logic [K_W-1:0] K_LAST = K_W'(CURVE_PTS - 1);

    localparam logic [RISE_W-1:0]    RISE_RESET   = RISE_W'(50);
    localparam logic [PCT_W-1:0]     CUTOFF_RESET = '0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = CFG_IDX_W'(1);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TOGGLE = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic [MV_W-1:0] voltage_mv;
        logic            power_request;
    } t_in_word;

    typedef struct packed {
        logic [PCT_W-1:0] charge_percent;
        logic             power_enabled;
        logic             cutoff_latched;
        logic             charging;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [MV_W-1:0] curve_mv(input logic [K_W-1:0] k);
        logic [MV_W-1:0] v;
        case (k)
            4'd0:    v = MV_W'(12600);
            4'd1:    v = MV_W'(12450);
            4'd2:    v = MV_W'(12240);
            4'd3:    v = MV_W'(12060);
            4'd4:    v = MV_W'(11880);
            4'd5:    v = MV_W'(11700);
            4'd6:    v = MV_W'(11520);
            4'd7:    v = MV_W'(11340);
            4'd8:    v = MV_W'(11160);
            4'd9:    v = MV_W'(10800);
            4'd10:   v = MV_W'(10200);
            4'd11:   v = MV_W'(9000);
            default: v = MV_W'(9000);
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] curve_pct(input logic [K_W-1:0] k);
        logic [PCT_W-1:0] p;
        case (k)
            4'd0:    p = PCT_W'(100);
            4'd1:    p = PCT_W'(90);
            4'd2:    p = PCT_W'(80);
            4'd3:    p = PCT_W'(70);
            4'd4:    p = PCT_W'(60);
            4'd5:    p = PCT_W'(50);
            4'd6:    p = PCT_W'(40);
            4'd7:    p = PCT_W'(30);
            4'd8:    p = PCT_W'(20);
            4'd9:    p = PCT_W'(10);
            4'd10:   p = PCT_W'(5);
            4'd11:   p = PCT_W'(0);
            default: p = PCT_W'(0);
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/battery_gauge_cutoff_monitor_unit.sv =====
// channel   direction  handshake               word
// in        input      i_in_valid / o_in_stall   t_in_word
// out       output     o_out_valid / i_out_stall t_out_word
// cfg       input      i_cfg_valid / o_cfg_ready index + data
//
// A voltage word goes from S_RANGE straight to S_DONE outside the curve, otherwise
// through S_SEARCH (one curve compare per cycle), S_MUL and a 4-step divider.
// A toggle word is applied in S_IDLE and yields no output word.
// Reset is synchronous, active low; the sample window needs no clearing.
// A stalled output word holds; the next word is taken while it waits.
module battery_gauge_cutoff_monitor_unit #(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bgcm_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bgcm_pkg::t_out_word                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bgcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bgcm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bgcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RANGE, S_SEARCH, S_MUL, S_DIV, S_DONE
    } t_state;

    t_state            r_state;
    logic [MV_W-1:0]   r_mv;
    logic [K_W-1:0]    r_k;
    logic [PCT_W-1:0]  r_pct;
    logic              r_power;
    logic              r_shut;
    logic [RISE_W-1:0] r_rise;
    logic [PCT_W-1:0]  r_cutoff;
    logic              r_out_valid;
    t_out_word         r_out_data;

    logic              w_in_acc;
    logic              w_sample;
    logic [K_W-1:0]    w_k1;
    logic [DEN_W-1:0]  w_dv;
    logic [Q_W-1:0]    w_rise_pct;
    logic [DIV_W-1:0]  w_prod;
    logic              w_charging;
    logic              w_cut;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_sample   = w_in_acc && (i_in_data.req_type == REQ_SAMPLE);
    assign w_k1       = r_k + K_W'(1);
    assign w_dv       = DEN_W'(r_mv - curve_mv(w_k1));
    assign w_rise_pct = Q_W'(curve_pct(r_k) - curve_pct(w_k1));
    assign w_prod     = DIV_W'(w_dv) * DIV_W'(w_rise_pct);
    assign w_cut      = (r_pct <= r_cutoff) && r_power;

    assign w_div_req.start = (r_state == S_MUL);
    assign w_div_req.num   = w_prod[NUM_W-1:0];
    assign w_div_req.den   = DEN_W'(curve_mv(r_k) - curve_mv(w_k1));

    bgcm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    bgcm_win #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_sample),
        .i_mv      (i_in_data.voltage_mv),
        .i_rise    (r_rise),
        .o_charging(w_charging)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_power     <= 1'b0;
            r_shut      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rise      <= RISE_RESET;
            r_cutoff    <= CUTOFF_RESET;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_RISE) begin
                    r_rise <= i_cfg_data;
                end else if (i_cfg_index == CFG_CUTOFF) begin
                    r_cutoff <= PCT_W'(i_cfg_data);
                end
            end
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_data.req_type == REQ_TOGGLE) begin
                            r_power <= i_in_data.power_request;
                            if (i_in_data.power_request) begin
                                r_shut <= 1'b0;
                            end
                        end else begin
                            r_state <= S_RANGE;
                        end
                    end
                end
                S_RANGE: begin
                    if (r_mv >= curve_mv('0)) begin
                        r_state <= S_DONE;
                    end else if (r_mv <= curve_mv(K_LAST)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (r_mv > curve_mv(w_k1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        if (w_cut) begin
                            r_power <= 1'b0;
                            r_shut  <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mv <= i_in_data.voltage_mv;
        end
        case (r_state)
            S_RANGE: begin
                r_k <= '0;
                if (r_mv >= curve_mv('0)) begin
                    r_pct <= curve_pct('0);
                end else begin
                    r_pct <= curve_pct(K_LAST);
                end
            end
            S_SEARCH: begin
                if (!(r_mv > curve_mv(w_k1))) begin
                    r_k <= w_k1;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_pct <= curve_pct(w_k1) + PCT_W'(w_div_rsp.quot);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out_data.charge_percent <= r_pct;
                    r_out_data.power_enabled  <= r_power && !w_cut;
                    r_out_data.cutoff_latched <= r_shut || w_cut;
                    r_out_data.charging       <= w_charging;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    a_shut_means_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shut |-> !r_power) else $error("shutdown flag with power on");
    a_turn_on_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.req_type == REQ_TOGGLE && i_in_data.power_request)
        |=> (r_power && !r_shut)) else $error("power-on toggle not applied");
    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_mv < curve_mv('0)) && (r_k < K_LAST))
        else $error("segment search out of range");
    a_pct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_out_data.charge_percent <= PCT_W'(100)))
        else $error("charge percent above full scale");

endmodule

// ===== rtl/bgcm_div.sv =====
module bgcm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bgcm_pkg::t_div_req i_req,
    output bgcm_pkg::t_div_rsp o_rsp
);
    import bgcm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [Q_W-1:0]    r_q;
    logic [DIV_W-1:0]  w_sh;
    logic              w_ge;

    assign w_sh = DIV_W'(r_den) << r_step;
    assign w_ge = DIV_W'(r_rem) >= w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(Q_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_q   <= '0;
        end else if (r_busy && w_ge) begin
            r_rem         <= r_rem - w_sh[NUM_W-1:0];
            r_q[r_step]   <= 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("divider restarted while busy");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (DEN_W+1)'(r_rem) < (DEN_W+1)'(r_den))
        else $error("divider remainder not reduced");

endmodule

// ===== rtl/bgcm_win.sv =====
module bgcm_win #(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [bgcm_pkg::MV_W-1:0]   i_mv,
    input  logic [bgcm_pkg::RISE_W-1:0] i_rise,
    output logic                        o_charging
);
    import bgcm_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

    logic [MV_W-1:0]  r_mem [WINDOW_DEPTH];
    logic [PTR_W-1:0] r_ptr;
    logic [PTR_W-1:0] n_ptr;
    logic             r_filled;
    logic             r_cmp;
    logic             r_charging;
    logic [MV_W-1:0]  r_oldest;
    logic [MV_W-1:0]  r_newest;

    assign n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_ptr] <= i_mv;
            r_oldest     <= r_mem[n_ptr];
            r_newest     <= i_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_filled   <= 1'b0;
            r_cmp      <= 1'b0;
            r_charging <= 1'b0;
        end else begin
            r_cmp <= i_wr;
            if (i_wr) begin
                r_ptr <= n_ptr;
                if (r_ptr == PTR_LAST) begin
                    r_filled <= 1'b1;
                end
            end
            if (r_cmp) begin
                r_charging <= r_filled && (r_newest > r_oldest)
                              && ((r_newest - r_oldest) > MV_W'(i_rise));
            end
        end
    end

    assign o_charging = r_charging;

endmodule
